// ----- design/lsap_pkg.sv -----
// Package for the line sensor array position block: payload types,
// constants, modes and sequencer states. No dependencies.
`default_nettype none
package lsap_pkg;
  localparam int NumSensorsDef = 8;
  localparam int SampleBitsDef = 12;
  localparam int FullScale = 1000;

  typedef enum logic [1:0] {
    MODE_READ = 2'd0,
    MODE_CAL  = 2'd1,
    MODE_CLR  = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_WAITS,
    ST_CENT,
    ST_WAITC,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    REG_MAXV = 2'd0,
    REG_INV  = 2'd1,
    REG_ONL  = 2'd2,
    REG_NOISE = 2'd3
  } reg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] raw_0;
    logic [11:0] raw_1;
    logic [11:0] raw_2;
    logic [11:0] raw_3;
    logic [11:0] raw_4;
    logic [11:0] raw_5;
    logic [11:0] raw_6;
    logic [11:0] raw_7;
  } in_item_t;

  typedef struct packed {
    logic [12:0] position;
    logic        on_line;
    logic [9:0]  level_0;
    logic [9:0]  level_1;
    logic [9:0]  level_2;
    logic [9:0]  level_3;
    logic [9:0]  level_4;
    logic [9:0]  level_5;
    logic [9:0]  level_6;
    logic [9:0]  level_7;
  } out_item_t;

  // handshake between sequencer and divider
  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;
endpackage
`default_nettype wire

// ----- design/lsap_div.sv -----
// Restoring radix-2 divider, one quotient bit per cycle.
// Has no package dependencies.
`default_nettype none
module lsap_div #(
  parameter int NW = 26,
  parameter int DW = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [NW-1:0]   num,
  input  wire logic [DW-1:0]   den,
  output logic                 busy,
  output logic [NW-1:0]        quo
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW:0]   trial;
  logic [DW+1:0] diff;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    trial = {rem_r[DW-1:0], q_r[NW-1]};
    diff = {1'b0, trial} - {2'b00, den_r};
    if (start) begin
      q_nxt = num;
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = CW'(NW);
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (!diff[DW+1]) begin
        rem_nxt = diff[DW:0];
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy = (cnt_r != '0);
  assign quo = q_r;
endmodule
`default_nettype wire

// ----- design/lsap_cal.sv -----
// Calibration store: per-sensor minimum and maximum in flip-flops.
// Uses lsap_pkg for mode codes.
`default_nettype none
module lsap_cal #(
  parameter int NS = lsap_pkg::NumSensorsDef,
  parameter int SB = lsap_pkg::SampleBitsDef
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  upd,
  input  wire logic [1:0]            mode,
  input  wire logic [NS-1:0][SB-1:0] raw,
  input  wire logic [SB-1:0]         maxv,
  input  wire logic [$clog2(NS)-1:0] sel,
  output logic [SB-1:0]              lo,
  output logic [SB-1:0]              hi
);
  localparam logic [SB-1:0] LowRst = SB'(2500 & ((1 << SB) - 1));
  logic [NS-1:0][SB-1:0] hi_r, hi_nxt, lo_r, lo_nxt;

  always_comb begin
    hi_nxt = hi_r;
    lo_nxt = lo_r;
    if (upd) begin
      for (int k = 0; k < NS; k++) begin
        if (mode == lsap_pkg::MODE_CAL) begin
          if (hi_r[k] < raw[k]) hi_nxt[k] = raw[k];
          if (lo_r[k] > raw[k]) lo_nxt[k] = raw[k];
        end else if (mode == lsap_pkg::MODE_CLR) begin
          hi_nxt[k] = '0;
          lo_nxt[k] = maxv;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_r <= '0;
      lo_r <= {NS{LowRst}};
    end else begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  assign lo = lo_r[sel];
  assign hi = hi_r[sel];
endmodule
`default_nettype wire

// ----- design/line_sensor_array_position.sv -----
// Line sensor array position: top level, sequencer, register port.
// Uses lsap_pkg, lsap_cal, lsap_div.
//
// Use: one transaction on in_ carries a scan of raw samples and a mode.
// Calibrate and reset-calibration modes update the stored min/max and
// return an all-zero result. Read mode scales every sensor to 0..1000
// (one shared restoring divider, one quotient bit a cycle), gathers the
// weighted sum and total serially, then divides once more for the
// centroid. Exactly one result per scan is offered on out_.
// Calibrate, reset and unused modes offer their result in the cycle after
// acceptance. Reads use the bit-serial divider of NW = max(SAMPLE_BITS+10, 26)
// bits. A sensor with degenerate calibration or a sample at or below its
// minimum skips the division. One scan is in flight at a time; in_stall
// is high from acceptance until its result has been taken.
// A stalled result holds on out_. Reset (rst_n low, synchronous) restores
// the register defaults, the calibration and the last position.
// Registers on cfg_: 0 max_value, 1 invert, 2 on_line_threshold,
// 3 noise_threshold at byte addresses 0,4,8,12.
`default_nettype none
module line_sensor_array_position #(
  parameter int NUM_SENSORS = lsap_pkg::NumSensorsDef,
  parameter int SAMPLE_BITS = lsap_pkg::SampleBitsDef
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire lsap_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output lsap_pkg::out_item_t       out_data,
  input  wire logic                 cfg_psel,
  input  wire logic                 cfg_penable,
  input  wire logic                 cfg_pwrite,
  input  wire logic [3:0]           cfg_paddr,
  input  wire logic [31:0]          cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);
  localparam int IW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int SB = SAMPLE_BITS;
  localparam int NW1 = SB + 10;   // (raw-lo)*1000
  localparam int NW2 = 26;        // weighted sum up to 7000*8000
  localparam int NW = (NW1 > NW2) ? NW1 : NW2;
  localparam int DW = (SB > 14) ? SB : 14;
  localparam logic [12:0] PosMax = 13'((NUM_SENSORS - 1) * lsap_pkg::FullScale);
  localparam logic [12:0] PosCtr = 13'((NUM_SENSORS - 1) * lsap_pkg::FullScale / 2);
  localparam logic [9:0] Full = 10'(lsap_pkg::FullScale);

  // configuration registers
  logic [11:0] maxv_r;
  logic        inv_r;
  logic [9:0]  onl_r, noise_r;
  logic        wr_en;
  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel & cfg_penable & cfg_pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maxv_r <= 12'd2500;
      inv_r <= 1'b0;
      onl_r <= 10'd200;
      noise_r <= 10'd50;
    end else if (wr_en) begin
      case (lsap_pkg::reg_t'(cfg_paddr[3:2]))
        lsap_pkg::REG_MAXV:  maxv_r <= cfg_pwdata[11:0];
        lsap_pkg::REG_INV:   inv_r <= cfg_pwdata[0];
        lsap_pkg::REG_ONL:   onl_r <= cfg_pwdata[9:0];
        lsap_pkg::REG_NOISE: noise_r <= cfg_pwdata[9:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (lsap_pkg::reg_t'(cfg_paddr[3:2]))
      lsap_pkg::REG_MAXV:  cfg_prdata = {20'd0, maxv_r};
      lsap_pkg::REG_INV:   cfg_prdata = {31'd0, inv_r};
      lsap_pkg::REG_ONL:   cfg_prdata = {22'd0, onl_r};
      lsap_pkg::REG_NOISE: cfg_prdata = {22'd0, noise_r};
      default:             cfg_prdata = '0;
    endcase
  end

  // sequencer
  lsap_pkg::state_t st_r, st_nxt;
  logic [1:0] mode_r;
  logic [NUM_SENSORS-1:0][SB-1:0] raw_r;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [7:0][9:0] lvl_r;
  logic [12:0] pos_r, last_r;
  logic seen_r, ovalid_r;
  logic [NW2-1:0] wsum_r;
  logic [13:0] tot_r;
  logic [12:0] wgt_r;   // idx*1000 running
  logic in_acc, out_acc, upd;
  logic div_start, div_busy;
  logic [NW-1:0] dnum, dquo;
  logic [DW-1:0] dden;
  logic [SB-1:0] lo, hi, rawk;
  logic degen;
  logic [9:0] lv, lvi;
  logic [NW2-1:0] prod_r;
  logic prod_v_r;

  assign in_acc = in_valid & ~in_stall;
  assign out_acc = out_valid & ~out_stall;
  assign in_stall = (st_r != lsap_pkg::ST_IDLE);
  assign out_valid = ovalid_r;

  logic [NUM_SENSORS-1:0][SB-1:0] raw_in;
  always_comb begin
    for (int k = 0; k < NUM_SENSORS; k++) begin
      raw_in[k] = in_data[95 - 12*k -: 12] & SB'((1 << SB) - 1);
    end
  end

  assign upd = in_acc;
  lsap_cal #(.NS(NUM_SENSORS), .SB(SB)) u_cal (
    .clk(clk), .rst_n(rst_n), .upd(upd), .mode(in_data.mode),
    .raw(raw_in), .maxv(maxv_r[SB-1:0]), .sel(idx_r), .lo(lo), .hi(hi)
  );

  assign rawk = raw_r[idx_r];
  assign degen = (hi <= lo) || (rawk <= lo);

  // the centroid waits until the last weighted product is summed
  always_comb begin
    dnum = '0;
    dden = '0;
    div_start = 1'b0;
    if (st_r == lsap_pkg::ST_SCALE && !degen) begin
      div_start = 1'b1;
      dnum = NW'((NW1'(rawk - lo)) * NW1'(lsap_pkg::FullScale));
      dden = DW'(hi - lo);
    end else if (st_r == lsap_pkg::ST_CENT && !prod_v_r && tot_r != '0) begin
      div_start = 1'b1;
      dnum = NW'(wsum_r);
      dden = DW'(tot_r);
    end
  end

  lsap_div #(.NW(NW), .DW(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(dnum), .den(dden),
    .busy(div_busy), .quo(dquo)
  );

  // level of the current sensor once the division is done
  always_comb begin
    if (degen) lv = '0;
    else if (dquo > NW'(lsap_pkg::FullScale)) lv = Full;
    else lv = dquo[9:0];
    lvi = inv_r ? (Full - lv) : lv;
  end

  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r;
    case (st_r)
      lsap_pkg::ST_IDLE:
        if (in_acc) begin
          st_nxt = (in_data.mode == lsap_pkg::MODE_READ) ? lsap_pkg::ST_SCALE
                                                          : lsap_pkg::ST_OUT;
          idx_nxt = '0;
        end
      lsap_pkg::ST_SCALE: st_nxt = degen ? lsap_pkg::ST_WAITS : lsap_pkg::ST_WAITS;
      lsap_pkg::ST_WAITS:
        if (!div_busy && !prod_v_r) begin
          if (32'(idx_r) == NUM_SENSORS - 1) st_nxt = lsap_pkg::ST_CENT;
          else begin
            st_nxt = lsap_pkg::ST_SCALE;
            idx_nxt = idx_r + 1'b1;
          end
        end
      lsap_pkg::ST_CENT: if (!prod_v_r) st_nxt = lsap_pkg::ST_WAITC;
      lsap_pkg::ST_WAITC: if (!div_busy) st_nxt = lsap_pkg::ST_OUT;
      lsap_pkg::ST_OUT: if (out_acc) st_nxt = lsap_pkg::ST_IDLE;
      default: st_nxt = lsap_pkg::ST_IDLE;
    endcase
  end

  // prod_v_r marks a valid registered weighting product in prod_r
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= lsap_pkg::ST_IDLE;
      idx_r <= '0;
      ovalid_r <= 1'b0;
      last_r <= '0;
      prod_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      idx_r <= idx_nxt;
      prod_v_r <= 1'b0;
      if (in_acc) begin
        mode_r <= in_data.mode;
        raw_r <= raw_in;
        lvl_r <= '0;
        seen_r <= 1'b0;
        wsum_r <= '0;
        tot_r <= '0;
        wgt_r <= '0;
        pos_r <= '0;
        ovalid_r <= (in_data.mode != lsap_pkg::MODE_READ);
      end
      if (st_r == lsap_pkg::ST_WAITS && !div_busy && !prod_v_r) begin
        lvl_r[idx_r] <= lvi;
        if (lvi > onl_r) seen_r <= 1'b1;
        if (lvi > noise_r) begin
          prod_r <= NW2'(lvi) * NW2'(wgt_r);
          prod_v_r <= 1'b1;
          tot_r <= tot_r + 14'(lvi);
        end
        wgt_r <= wgt_r + 13'(lsap_pkg::FullScale);
      end
      if (prod_v_r) wsum_r <= wsum_r + prod_r;
      if (st_r == lsap_pkg::ST_WAITC && !div_busy) begin
        ovalid_r <= 1'b1;
        if (!seen_r) pos_r <= (last_r < PosCtr) ? 13'd0 : PosMax;
        else if (tot_r != '0) begin
          pos_r <= dquo[12:0];
          last_r <= dquo[12:0];
        end else pos_r <= last_r;
      end
      if (out_acc) ovalid_r <= 1'b0;
    end
  end

  always_comb begin
    out_data = '0;
    if (mode_r == lsap_pkg::MODE_READ) begin
      out_data.position = pos_r;
      out_data.on_line = seen_r;
      out_data.level_0 = lvl_r[0];
      out_data.level_1 = lvl_r[1];
      out_data.level_2 = lvl_r[2];
      out_data.level_3 = lvl_r[3];
      out_data.level_4 = lvl_r[4];
      out_data.level_5 = lvl_r[5];
      out_data.level_6 = lvl_r[6];
      out_data.level_7 = lvl_r[7];
    end
  end
endmodule
`default_nettype wire

// ----- design/lsap_chk.sv -----
// Port-level checker for line_sensor_array_position, with its bind.
// Depends on lsap_pkg and the top level's ports.
`default_nettype none
module lsap_chk (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire lsap_pkg::out_item_t out_data
);
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.position <= 13'd7000) else $error("position range");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("accept while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("hold");
  a_off: assert property (@(posedge clk) disable iff (!rst_n)
    !out_data.on_line && out_valid |-> out_data.position == 13'd0
      || out_data.position == 13'd7000) else $error("off-line position");
endmodule
bind line_sensor_array_position lsap_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire

// ----- verif/tb_line_sensor_array_position.sv -----
// Testbench for line_sensor_array_position: scan stimulus, APB register writes,
// and a scoreboard that predicts each result. Depends on lsap_pkg and the RTL.
`default_nettype none
module tb_line_sensor_array_position;
  timeunit 1ns;
  timeprecision 1ps;

  class scan_scoreboard;
    logic [11:0] max_value = 12'd2500;
    logic        invert = 1'b0;
    logic [9:0]  onl_thr = 10'd200;
    logic [9:0]  noise_thr = 10'd50;
    logic [11:0] cal_hi [8];
    logic [11:0] cal_lo [8];
    logic [12:0] last_pos = '0;
    lsap_pkg::out_item_t pending [$];
    int          errors = 0;

    function new();
      foreach (cal_hi[k]) begin
        cal_hi[k] = '0;
        cal_lo[k] = 12'd2500;
      end
    endfunction

    function void write_reg(lsap_pkg::reg_t r, logic [31:0] v);
      case (r)
        lsap_pkg::REG_MAXV:  max_value = v[11:0];
        lsap_pkg::REG_INV:   invert = v[0];
        lsap_pkg::REG_ONL:   onl_thr = v[9:0];
        lsap_pkg::REG_NOISE: noise_thr = v[9:0];
        default: ;
      endcase
    endfunction

    function logic [9:0] scale(logic [11:0] raw, logic [11:0] lo, logic [11:0] hi);
      int unsigned q;
      if (hi <= lo || raw <= lo) return 10'd0;
      q = ((raw - lo) * 1000) / (hi - lo);
      return (q > 1000) ? 10'd1000 : q[9:0];
    endfunction

    function void note_scan(lsap_pkg::in_item_t it);
      logic [11:0] raw [8];
      logic [9:0]  lvl [8];
      longint unsigned weighted;
      int unsigned total;
      bit seen;
      logic [12:0] pos;
      lsap_pkg::out_item_t res;
      raw = '{it.raw_0, it.raw_1, it.raw_2, it.raw_3,
              it.raw_4, it.raw_5, it.raw_6, it.raw_7};
      weighted = 0; total = 0; seen = 0; pos = '0;
      foreach (lvl[k]) lvl[k] = '0;
      case (lsap_pkg::mode_t'(it.mode))
        lsap_pkg::MODE_CAL: foreach (raw[k]) begin
          if (cal_hi[k] < raw[k]) cal_hi[k] = raw[k];
          if (cal_lo[k] > raw[k]) cal_lo[k] = raw[k];
        end
        lsap_pkg::MODE_CLR: foreach (raw[k]) begin
          cal_hi[k] = '0;
          cal_lo[k] = max_value;
        end
        lsap_pkg::MODE_READ: begin
          foreach (raw[k]) begin
            lvl[k] = scale(raw[k], cal_lo[k], cal_hi[k]);
            if (invert) lvl[k] = 10'd1000 - lvl[k];
            if (lvl[k] > onl_thr) seen = 1;
            if (lvl[k] > noise_thr) begin
              weighted += longint'(lvl[k]) * k * 1000;
              total += lvl[k];
            end
          end
          if (!seen) pos = (last_pos < 3500) ? 13'd0 : 13'd7000;
          else begin
            if (total != 0) last_pos = 13'(weighted / total);
            pos = last_pos;
          end
        end
        default: ;
      endcase
      res.position = pos; res.on_line = seen;
      res.level_0 = lvl[0]; res.level_1 = lvl[1]; res.level_2 = lvl[2];
      res.level_3 = lvl[3]; res.level_4 = lvl[4]; res.level_5 = lvl[5];
      res.level_6 = lvl[6]; res.level_7 = lvl[7];
      pending.push_back(res);
    endfunction

    function void check_result(lsap_pkg::out_item_t got);
      lsap_pkg::out_item_t exp;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: pos %0d/%0d on %0d/%0d levels %h / %h",
                   exp.position, got.position, exp.on_line, got.on_line,
                   exp[79:0], got[79:0]);
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  lsap_pkg::in_item_t in_data = '0;
  lsap_pkg::out_item_t out_data;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0, cfg_pready;
  logic [3:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0, cfg_prdata;
  int send_idle = 0, recv_stall = 0;
  int unsigned cycles = 0;
  scan_scoreboard sb = new();

  line_sensor_array_position dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 2_000_000) begin
      $display("[line_sensor_array_position] ERROR");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall);

  // setup cycle, then access cycle
  task automatic write_reg(lsap_pkg::reg_t r, logic [31:0] v);
    @(negedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_paddr <= {r, 2'b00}; cfg_pwdata <= v;
    @(negedge clk) cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
    sb.write_reg(r, v);
    @(negedge clk) begin
      cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    end
  endtask

  // the block raises in_stall after each acceptance, until the result is taken
  task automatic send_scan(lsap_pkg::in_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) @(negedge clk);
    in_valid <= 1; in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_scan(it);
    @(negedge clk) in_valid <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic lsap_pkg::in_item_t make_scan(lsap_pkg::mode_t m, int lo, int hi);
    lsap_pkg::in_item_t it;
    it = lsap_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom});
    it.mode = m;
    it.raw_0 = 12'($urandom_range(hi, lo)); it.raw_1 = 12'($urandom_range(hi, lo));
    it.raw_2 = 12'($urandom_range(hi, lo)); it.raw_3 = 12'($urandom_range(hi, lo));
    it.raw_4 = 12'($urandom_range(hi, lo)); it.raw_5 = 12'($urandom_range(hi, lo));
    it.raw_6 = 12'($urandom_range(hi, lo)); it.raw_7 = 12'($urandom_range(hi, lo));
    return it;
  endfunction

  // random mix of calibration resets, calibration scans, line reads and noise modes
  task automatic run_phase(int n);
    int base, span;
    for (int i = 0; i < n; i++) begin
      int r = $urandom_range(99);
      base = $urandom_range(1500);
      span = $urandom_range(2500, 1);
      if (r < 4) send_scan(make_scan(lsap_pkg::MODE_CLR, 0, 4095));
      else if (r < 18) send_scan(make_scan(lsap_pkg::MODE_CAL, base, base + span));
      else if (r < 21) send_scan(make_scan(lsap_pkg::MODE_NONE, 0, 4095));
      else if (r < 30) send_scan(make_scan(lsap_pkg::MODE_READ, 0, 4095));
      else send_scan(make_scan(lsap_pkg::MODE_READ, base, base + span));
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed: reset calibration is degenerate, then extremes
    send_scan(make_scan(lsap_pkg::MODE_READ, 0, 4095));
    send_scan('{lsap_pkg::MODE_CAL, 12'hFFF, 0, 12'hFFF, 0, 12'hFFF, 0, 12'hFFF, 0});
    send_scan('{lsap_pkg::MODE_CAL, 0, 12'hFFF, 0, 12'hFFF, 0, 12'hFFF, 0, 12'hFFF});
    send_scan('{lsap_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0});
    send_scan('{lsap_pkg::MODE_READ, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
                12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF});
    send_scan('{lsap_pkg::MODE_READ, 12'hFFF, 0, 0, 0, 0, 0, 0, 0});
    send_scan('{lsap_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 12'hFFF});
    send_scan('{lsap_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0});
    send_scan('{lsap_pkg::MODE_READ, 0, 0, 0, 100, 0, 0, 0, 0});
    send_scan('{lsap_pkg::MODE_NONE, 12'hFFF, 1, 2, 3, 4, 5, 6, 7});
    drain();
    write_reg(lsap_pkg::REG_NOISE, 32'd1000);
    send_scan('{lsap_pkg::MODE_READ, 0, 0, 0, 12'hFFF, 0, 0, 0, 0});
    drain();
    write_reg(lsap_pkg::REG_INV, 32'd1);
    write_reg(lsap_pkg::REG_ONL, 32'd0);
    write_reg(lsap_pkg::REG_NOISE, 32'd0);
    send_scan('{lsap_pkg::MODE_READ, 12'hFFF, 0, 12'h800, 0, 12'h400, 0, 0, 0});
    drain();
    write_reg(lsap_pkg::REG_MAXV, 32'd0);
    send_scan('{lsap_pkg::MODE_CLR, 0, 0, 0, 0, 0, 0, 0, 0});
    send_scan('{lsap_pkg::MODE_READ, 5, 5, 5, 5, 5, 5, 5, 5});
    drain();
    write_reg(lsap_pkg::REG_MAXV, 32'hFFF);
    write_reg(lsap_pkg::REG_INV, 32'd0);
    write_reg(lsap_pkg::REG_ONL, 32'd1000);
    send_scan('{lsap_pkg::MODE_CLR, 0, 0, 0, 0, 0, 0, 0, 0});
    send_scan(make_scan(lsap_pkg::MODE_CAL, 0, 4095));
    send_scan(make_scan(lsap_pkg::MODE_READ, 0, 4095));
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(lsap_pkg::REG_MAXV, ph == 0 ? 32'd2500 : $urandom_range(4095));
      write_reg(lsap_pkg::REG_INV, $urandom_range(1));
      write_reg(lsap_pkg::REG_ONL, ph == 4 ? 32'd0 : $urandom_range(700));
      write_reg(lsap_pkg::REG_NOISE, ph == 3 ? 32'd1000 : $urandom_range(300));
      send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 59 : 38) : 0;
      recv_stall = (ph == 2) ? 59 : (ph == 3 ? 38 : 0);
      send_scan('{lsap_pkg::MODE_CLR, 0, 0, 0, 0, 0, 0, 0, 0});
      run_phase(345);
      drain();
    end
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[line_sensor_array_position] OK");
    else
      $display("[line_sensor_array_position] ERROR");
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
design/lsap_pkg.sv
design/lsap_div.sv
design/lsap_cal.sv
design/line_sensor_array_position.sv
design/lsap_chk.sv
verif/tb_line_sensor_array_position.sv
